// File: sv/b64lw_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 line-wrap encoder.
package b64lw_pkg;

    localparam int unsigned WrapW    = 10;
    localparam int unsigned MaxChars = 5;
    localparam int unsigned PosW     = $clog2(MaxChars + 1);

    localparam logic [7:0]       LineFeed  = 8'h0a;
    localparam logic [7:0]       PadChar   = 8'h3d;
    localparam logic [WrapW-1:0] WrapReset = 10'd100;

    // input word: one raw byte and the end-of-stream flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_word;

    // output word: one character and the end-of-run flag
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } t_out_word;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] ch;
        case (v) inside
            [6'd0:6'd25]:  ch = 8'h41 + {2'b00, v};
            [6'd26:6'd51]: ch = 8'h61 + {2'b00, v} - 8'd26;
            [6'd52:6'd61]: ch = 8'h30 + {2'b00, v} - 8'd52;
            6'd62:         ch = 8'h2b;
            default:       ch = 8'h2f;
        endcase
        return ch;
    endfunction

endpackage

// File: sv/base64_encoder_line_wrap.sv
// Streaming base64 encoder with line feed insertion after a full line.
//
// Input channel: one raw byte per word with an end-of-stream flag
// (i_in_valid / o_in_stall). Output channel: one character per word with a
// flag on the last character caused by an input byte (o_out_valid /
// i_out_stall). The user must write the wrap width register (i_cfg_we,
// i_cfg_data) only while the block is idle; the block does not enforce it.
//
// A byte that completes a group of three, or ends the stream, loads up to
// five characters into a group buffer in the cycle it is accepted. The
// buffer drains one character per cycle into the output register while the
// output is not stalled; each character passes through the group buffer
// and then the output register. A new byte is taken in the same cycle the
// buffer's last character moves out; bytes that are only held are then
// taken one per cycle.
//
// When the receiver stalls, the output word holds and the buffer stops;
// the input stalls until the buffer can be refilled. Reset empties the
// buffer and output register, clears held bytes and the line count, and
// sets the wrap width to 100.
module base64_encoder_line_wrap (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [9:0]                i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  b64lw_pkg::t_in_word       i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output b64lw_pkg::t_out_word      o_out_data
);
    import b64lw_pkg::*;

    logic [WrapW-1:0] r_wrap;
    logic [15:0]      r_pend;
    logic [1:0]       r_pend_cnt;
    logic [WrapW-1:0] r_line;
    logic [7:0]       r_buf [MaxChars];
    logic [PosW-1:0]  r_len;
    logic [PosW-1:0]  r_pos;
    logic             r_out_valid;
    t_out_word        r_out;

    logic [7:0]       n_buf [MaxChars];
    logic [PosW-1:0]  n_len;
    logic [15:0]      n_pend;
    logic [1:0]       n_pend_cnt;
    logic [WrapW-1:0] n_line;
    logic [WrapW:0]   total;
    logic [7:0]       a_byte;
    logic [7:0]       b_byte;
    logic             buf_has;
    logic             out_free;
    logic             move;
    logic             last_move;
    logic             accept;

    // buffer drain and input handshake
    assign buf_has    = (r_pos != r_len);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = buf_has && out_free;
    assign last_move  = (r_pos + 1'b1) == r_len;
    assign o_in_stall = buf_has && !(move && last_move);
    assign accept     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // encode one byte into the next group and state
    always_comb begin
        a_byte     = r_pend[15:8];
        b_byte     = r_pend[7:0];
        total      = {1'b0, r_line} + (WrapW+1)'(4);
        n_pend     = r_pend;
        n_pend_cnt = r_pend_cnt;
        n_line     = r_line;
        n_len      = '0;
        for (int i = 0; i < MaxChars; i++) begin
            n_buf[i] = LineFeed;
        end
        if (r_pend_cnt[1]) begin
            // full group of three bytes
            n_buf[0] = sym(a_byte[7:2]);
            n_buf[1] = sym({a_byte[1:0], b_byte[7:4]});
            n_buf[2] = sym({b_byte[3:0], i_in_data.data_byte[7:6]});
            n_buf[3] = sym(i_in_data.data_byte[5:0]);
            if (total >= {1'b0, r_wrap}) begin
                n_len  = PosW'(5);
                n_line = '0;
            end else begin
                n_len  = PosW'(4);
                n_line = total[WrapW-1:0];
            end
            n_pend     = '0;
            n_pend_cnt = '0;
        end else if (!i_in_data.end_of_stream) begin
            // hold the byte
            n_pend     = {r_pend[7:0], i_in_data.data_byte};
            n_pend_cnt = r_pend_cnt + 2'd1;
        end else if (r_pend_cnt == 2'd0) begin
            // one final byte, two pads
            n_buf[0] = sym(i_in_data.data_byte[7:2]);
            n_buf[1] = sym({i_in_data.data_byte[1:0], 4'b0000});
            n_buf[2] = PadChar;
            n_buf[3] = PadChar;
            n_len    = PosW'(4);
        end else begin
            // two final bytes, one pad
            n_buf[0] = sym(b_byte[7:2]);
            n_buf[1] = sym({b_byte[1:0], i_in_data.data_byte[7:4]});
            n_buf[2] = sym({i_in_data.data_byte[3:0], 2'b00});
            n_buf[3] = PadChar;
            n_len    = PosW'(4);
        end
        if (i_in_data.end_of_stream) begin
            n_pend     = '0;
            n_pend_cnt = '0;
            n_line     = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap      <= WrapReset;
            r_pend      <= '0;
            r_pend_cnt  <= '0;
            r_line      <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wrap <= i_cfg_data;
            end
            if (accept) begin
                r_pend     <= n_pend;
                r_pend_cnt <= n_pend_cnt;
                r_line     <= n_line;
                r_len      <= n_len;
                r_pos      <= '0;
            end else if (move) begin
                r_pos <= r_pos + 1'b1;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: group buffer and output word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= n_buf;
        end
        if (move) begin
            r_out.out_char    <= r_buf[r_pos];
            r_out.last_of_run <= last_move;
        end
    end

endmodule

// File: tb/tb_base64_encoder_line_wrap.sv
// Self-checking testbench for the base64 line-wrap encoder: directed table, then random streams.
module tb_base64_encoder_line_wrap;
    import b64lw_pkg::*;

    localparam int    DirRows   = 25;
    localparam int    LongHold  = 60;    // receiver hold-off, in cycles
    localparam int    Settle    = 8;     // quiet cycles before a wrap width write
    localparam int    IdleLimit = 1000;  // cycles without any handshake
    localparam string B64Alpha  =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [9:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    t_in_word   in_word;
    logic       out_valid;
    logic       out_stall;
    t_out_word  out_word;

    // encoder state as the checker sees it
    logic [15:0] held_bytes = '0;
    logic [1:0]  held_cnt   = '0;
    logic [9:0]  line_col   = '0;
    logic [9:0]  wrap_w     = WrapReset;

    logic [7:0] group_chars[$];   // characters caused by the word just taken
    t_out_word  char_fifo[$];     // characters still owed by the encoder
    string      word_tag;         // "?" = predicted, else the literal expected text

    int  errors = 0, quiet = 0;
    int  bytes_sent = 0, bytes_in = 0, chars_seen = 0, lf_seen = 0, stall_cycles = 0;
    int  hold_done = 0;
    bit  tx_calm, rx_calm, hold_req;

    // directed table: byte, end flag, wrap write before the row (-1 none), expected text
    logic [7:0] dir_byte [DirRows] = '{
        8'h4d, 8'h61, 8'h6e, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hfb, 8'hef, 8'hbe, 8'h00, 8'h10, 8'h83, 8'h01, 8'h02, 8'h03, 8'ha5,
        8'h5a, 8'hc3, 8'h7e, 8'h81, 8'h3c};
    bit dir_eos [DirRows] = '{
        0, 0, 0, 1, 1, 0, 1, 0, 0, 0,
        0, 0, 1, 0, 0, 0, 0, 0, 0, 0,
        0, 0, 0, 0, 1};
    int dir_wrap [DirRows] = '{
        -1, -1, -1, -1, -1, -1, -1, -1, -1, -1,
        -1, -1, -1,  0, -1, -1, 1023, -1, -1, -1,
        -1, -1,  2, -1, -1};
    string dir_chars [DirRows] = '{
        "", "", "TWFu", "AA==", "/w==", "", "//8=", "", "", "////",
        "", "", "++++", "?", "?", "?", "?", "?", "?", "?",
        "?", "?", "?", "?", "?"};

    base64_encoder_line_wrap u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_word)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] alpha(input logic [5:0] v);
        return B64Alpha[v];
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // advance the encoder state by one word; characters land in group_chars
    function automatic void encode_byte(input t_in_word w);
        logic [7:0]  a, b, d;
        logic [10:0] total;
        d = w.data_byte;
        group_chars.delete();
        if (held_cnt >= 2'd2) begin
            a = held_bytes[15:8];
            b = held_bytes[7:0];
            group_chars.push_back(alpha(a[7:2]));
            group_chars.push_back(alpha({a[1:0], b[7:4]}));
            group_chars.push_back(alpha({b[3:0], d[7:6]}));
            group_chars.push_back(alpha(d[5:0]));
            total = {1'b0, line_col} + 11'd4;
            // line full: feed and restart the count
            if (total >= {1'b0, wrap_w}) begin
                group_chars.push_back(LineFeed);
                total = '0;
            end
            line_col   = total[9:0];
            held_bytes = '0;
            held_cnt   = '0;
        end else if (!w.end_of_stream) begin
            held_bytes = {held_bytes[7:0], d};
            held_cnt   = held_cnt + 2'd1;
        end else if (held_cnt == 2'd0) begin
            group_chars.push_back(alpha(d[7:2]));
            group_chars.push_back(alpha({d[1:0], 4'b0000}));
            group_chars.push_back(PadChar);
            group_chars.push_back(PadChar);
        end else begin
            a = held_bytes[7:0];
            group_chars.push_back(alpha(a[7:2]));
            group_chars.push_back(alpha({a[1:0], d[7:4]}));
            group_chars.push_back(alpha({d[3:0], 2'b00}));
            group_chars.push_back(PadChar);
        end
        // end of stream: next byte starts a fresh line
        if (w.end_of_stream) begin
            held_bytes = '0;
            held_cnt   = '0;
            line_col   = '0;
        end
    endfunction

    function automatic void flag_miss(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
        errors++;
        if (errors <= 40)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    // scoreboard: check output words, then predict for the input word taken
    always @(posedge clk) begin : scoreboard
        t_out_word want;
        int        n;
        if (rst_n && out_valid && !out_stall) begin
            chars_seen++;
            if (out_word.out_char == LineFeed) lf_seen++;
            if (char_fifo.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                             out_word.out_char, out_word.last_of_run);
            end else begin
                want = char_fifo.pop_front();
                if (out_word.out_char !== want.out_char)
                    flag_miss("out_char", want.out_char, out_word.out_char);
                if (out_word.last_of_run !== want.last_of_run)
                    flag_miss("last_of_run", 8'(want.last_of_run), 8'(out_word.last_of_run));
            end
        end
        if (cfg_we) wrap_w = cfg_data;
        if (rst_n && in_valid && !in_stall) begin
            bytes_in++;
            encode_byte(in_word);
            if (word_tag != "?") begin
                group_chars.delete();
                for (int k = 0; k < word_tag.len(); k++) group_chars.push_back(word_tag[k]);
            end
            n = group_chars.size();
            for (int k = 0; k < n; k++)
                char_fifo.push_back(t_out_word'{out_char: group_chars[k],
                                                last_of_run: (k == n - 1)});
        end
        if (in_valid && in_stall) stall_cycles++;
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet = 0;
        else
            quiet++;
        if (quiet >= IdleLimit) begin
            $display("%0t: no handshake for %0d cycles, %0d words still owed", $time,
                     quiet, char_fifo.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall runs, calm stretches, one long hold-off on request
    initial begin : receiver
        int  run_left;
        bit  stalling;
        run_left  = 0;
        stalling  = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (LongHold) @(negedge clk);
                hold_req = 1'b0;
                hold_done++;
                run_left = 0;
            end else if (rx_calm) begin
                out_stall <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    stalling = ($urandom_range(0, 99) < 35);
                    run_left = stalling ? pick_gap() + 1 : $urandom_range(1, 12);
                end
                out_stall <= stalling;
                run_left--;
            end
        end
    end

    // offer one word, return once it is taken
    task automatic send_word(input logic [7:0] d, input logic eos, input string tag);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= t_in_word'{data_byte: d, end_of_stream: eos};
        word_tag = tag;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // random stream, bytes biased toward the extremes
    task automatic send_stream(input int len, input bit closed);
        int         r;
        logic [7:0] d;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            d = (r < 8) ? 8'h00 : (r < 16) ? 8'hff : 8'($urandom_range(0, 255));
            send_word(d, closed && (k == len - 1), "?");
        end
    endtask

    // stop offering, wait for every owed word, then let the block go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (char_fifo.size() != 0) @(negedge clk);
        repeat (Settle) @(negedge clk);
    endtask

    task automatic set_wrap(input logic [9:0] width);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= width;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int goal;
        bit paused;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        word_tag = "?";
        tx_calm  = 1'b0;
        rx_calm  = 1'b0;
        hold_req = 1'b0;
        paused   = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DirRows; i++) begin
            if (dir_wrap[i] >= 0) set_wrap(10'(dir_wrap[i]));
            send_word(dir_byte[i], dir_eos[i], dir_chars[i]);
        end

        // random phases: one wrap width each
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       set_wrap(10'd1);
                1:       set_wrap(10'($urandom_range(5, 30)));
                2:       set_wrap(WrapReset);
                3:       set_wrap(10'd1023);
                default: set_wrap(10'($urandom_range(2, 12)));
            endcase
            tx_calm = (phase == 1);
            rx_calm = (phase == 1);
            // back-pressure: receiver holds off while words keep coming
            if (phase == 2) begin
                hold_req = 1'b1;
                tx_calm  = 1'b1;
            end
            goal = bytes_sent + 10;
            while (bytes_sent < goal) begin
                if (phase == 2 && hold_done > 0) tx_calm = 1'b0;
                // sender pause until the output has fully drained
                if (phase == 3 && !paused && bytes_sent >= goal - 5) begin
                    settle();
                    paused = 1'b1;
                end
                send_stream($urandom_range(1, 12), $urandom_range(0, 4) != 0);
            end
            // long open line so the next, narrower width lands below the count
            if (phase == 3) send_stream(9, 1'b0);
        end

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();

        $display("Run covered %0d bytes in and %0d characters out, %0d of them line feeds,",
                 bytes_in, chars_seen, lf_seen);
        $display("wrap widths from 0 to 1023, and %0d cycles of input held back by stalls.",
                 stall_cycles);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
